// ----- src/next_lexicographic_permutation_core_macros.svh -----
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_core_macros
// assertion macros for the permutation core rtl
// ----------------------------------------------------------------------------
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define NLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define NLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nlp_pkg.sv -----
// ----------------------------------------------------------------------------
// nlp_pkg
// shared constants, codes and types of the permutation core
// ----------------------------------------------------------------------------
package nlp_pkg;

    // store geometry
    localparam int MAX_LEN   = 16;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);

    // fixed field widths
    localparam int DATA_W    = 8;
    localparam int POS_W     = 4;
    localparam int CFG_LEN_W = 5;

    // configuration port
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_LENGTH = 0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_SUCC_RD,
        S_SUCC_CMP,
        S_SWAP_WR,
        S_REV_CHK,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_EMIT_ZERO
    } t_state;

    // accepted request toward the sequencer
    typedef struct packed {
        logic              start;
        t_op               op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // one emitted result from the sequencer
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  out_position;
        logic              advanced;
        logic              last_element;
    } t_emit;

endpackage

// ----- src/nlp_if.sv -----
// ----------------------------------------------------------------------------
// nlp_req_if / nlp_rsp_if
// valid/ready channels for requests and emitted results
// ----------------------------------------------------------------------------
interface nlp_req_if;
    import nlp_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;

    modport source (output valid, op, position, value, input ready);
    modport sink   (input valid, op, position, value, output ready);
endinterface

interface nlp_rsp_if;
    import nlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] element;
    logic [POS_W-1:0]  out_position;
    logic              advanced;
    logic              last_element;

    modport source (output valid, element, out_position, advanced, last_element, input ready);
    modport sink   (input valid, element, out_position, advanced, last_element, output ready);
endinterface

// ----- src/next_lexicographic_permutation_core.sv -----
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_core: next lexicographic permutation engine
// load request writes one byte; step on n >= 2 bytes swaps any rightmost ascent's pivot
// with its successor, reverses the suffix, then emits each result under output
// stalls; n < 2 just emits; no request is taken until the last result is handed off
// sync active-low reset clears the sequencer, length and output valid, not stored bytes
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    nlp_req_if.sink                     i_req,
    nlp_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nlp_pkg::PADDR_W-1:0] paddr,
    input  logic [nlp_pkg::PDATA_W-1:0] pwdata,
    output logic [nlp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import nlp_pkg::*;

    // stored bytes stay undefined until loaded

    logic [CFG_LEN_W-1:0] r_len, n_len;
    logic                 r_ovalid, n_ovalid;
    t_emit                r_out, n_out;

    logic   seq_idle;
    logic   out_free;
    logic   sel_len;
    t_cmd   cmd;
    t_emit  emit;

    // configuration port
    assign pready  = 1'b1;
    assign sel_len = (int'(paddr[PADDR_W-1:2]) == REG_LENGTH);
    assign prdata  = sel_len ? PDATA_W'(r_len) : '0;

    always_comb begin
        n_len = r_len;
        if (psel && penable && pwrite && sel_len) begin
            n_len = pwdata[CFG_LEN_W-1:0];
        end
    end

    // request channel
    assign i_req.ready  = seq_idle;
    assign cmd.start    = i_req.valid && seq_idle;
    assign cmd.op       = t_op'(i_req.op);
    assign cmd.position = i_req.position;
    assign cmd.value    = i_req.value;

    nlp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_len      (r_len),
        .i_out_free (out_free),
        .o_idle     (seq_idle),
        .o_emit     (emit)
    );

    // output register
    assign out_free = !r_ovalid || o_rsp.ready;

    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (emit.vld) begin
            n_ovalid = 1'b1;
            n_out    = emit;
        end else if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.element      = r_out.element;
    assign o_rsp.out_position = r_out.out_position;
    assign o_rsp.advanced     = r_out.advanced;
    assign o_rsp.last_element = r_out.last_element;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ----- src/nlp_ram.sv -----
// ----------------------------------------------------------------------------
// nlp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/nlp_seq.sv -----
// ----------------------------------------------------------------------------
// nlp_seq
// sequencer that steps the stored bytes through one shared comparator
// ----------------------------------------------------------------------------
`include "next_lexicographic_permutation_core_macros.svh"

module nlp_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nlp_pkg::t_cmd                 i_cmd,
    input  logic [nlp_pkg::CFG_LEN_W-1:0] i_len,
    input  logic                          i_out_free,
    output logic                          o_idle,
    output nlp_pkg::t_emit                o_emit
);
    import nlp_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_last, n_last;
    logic [DATA_W-1:0] r_hold, n_hold;
    logic              r_adv, n_adv;

    logic [LEN_W-1:0]  len_eff;
    logic              step_req;
    logic [DATA_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    // sequence store
    nlp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // length clamped to the store size
    always_comb begin
        if (int'(i_len) > MAX_LEN) begin
            len_eff = LEN_W'(MAX_LEN);
        end else begin
            len_eff = LEN_W'(i_len);
        end
    end

    assign step_req = i_cmd.start && (i_cmd.op == OP_STEP);
    assign o_idle   = (r_state == S_IDLE);

    // shared byte comparator
    always_comb begin
        if (r_state == S_SUCC_CMP) begin
            cmp_a = r_hold;
            cmp_b = ram_rdata;
        end else begin
            cmp_a = ram_rdata;
            cmp_b = r_hold;
        end
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (step_req) begin
                    if (len_eff == '0) begin
                        n_state = S_EMIT_ZERO;
                    end else if (len_eff == LEN_W'(1)) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD:   n_state = S_FIND_CMP;
            S_FIND_CMP: begin
                if (r_i == r_last) begin
                    n_state = S_FIND_RD;
                end else if (cmp_lt) begin
                    n_state = S_SUCC_RD;
                end else if (r_i == '0) begin
                    n_state = S_REV_CHK;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_SUCC_RD:   n_state = S_SUCC_CMP;
            S_SUCC_CMP: begin
                n_state = cmp_lt ? S_SWAP_WR : S_SUCC_RD;
            end
            S_SWAP_WR:   n_state = S_REV_CHK;
            S_REV_CHK: begin
                n_state = (r_i < r_j) ? S_REV_RD_LO : S_EMIT_RD;
            end
            S_REV_RD_LO: n_state = S_REV_RD_HI;
            S_REV_RD_HI: n_state = S_REV_WR_LO;
            S_REV_WR_LO: n_state = S_REV_WR_HI;
            S_REV_WR_HI: n_state = S_REV_CHK;
            S_EMIT_RD:   n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (i_out_free) begin
                    n_state = (r_i == r_last) ? S_IDLE : S_EMIT_RD;
                end
            end
            S_EMIT_ZERO: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath, store access and result output
    always_comb begin
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_last    = r_last;
        n_hold    = r_hold;
        n_adv     = r_adv;
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = ram_rdata;
        ram_raddr = r_i;
        o_emit    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start && (i_cmd.op == OP_LOAD)) begin
                    ram_we    = (int'(i_cmd.position) < MAX_LEN);
                    ram_waddr = IDX_W'(i_cmd.position);
                    ram_wdata = i_cmd.value;
                end
                if (step_req) begin
                    n_last = IDX_W'(len_eff - LEN_W'(1));
                    n_i    = IDX_W'(len_eff - LEN_W'(1));
                    n_adv  = 1'b0;
                end
            end
            S_FIND_RD: begin
                ram_raddr = r_i;
            end
            // scan right to left for the rightmost ascent
            S_FIND_CMP: begin
                n_hold = ram_rdata;
                if (r_i == r_last) begin
                    n_i = r_i - IDX_W'(1);
                end else if (cmp_lt) begin
                    n_k = r_i;
                    n_j = r_last;
                end else if (r_i == '0) begin
                    n_i = '0;
                    n_j = r_last;
                end else begin
                    n_i = r_i - IDX_W'(1);
                end
            end
            S_SUCC_RD: begin
                ram_raddr = r_j;
            end
            // rightmost byte above the pivot, first half of the swap
            S_SUCC_CMP: begin
                ram_raddr = r_j;
                if (cmp_lt) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_k;
                    ram_wdata = ram_rdata;
                end else begin
                    n_j = r_j - IDX_W'(1);
                end
            end
            S_SWAP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_hold;
                n_adv     = 1'b1;
                n_i       = r_k + IDX_W'(1);
                n_j       = r_last;
            end
            // suffix reversal, one pair at a time
            S_REV_CHK: begin
                if (!(r_i < r_j)) begin
                    n_i = '0;
                end
            end
            S_REV_RD_LO: begin
                ram_raddr = r_i;
            end
            S_REV_RD_HI: begin
                ram_raddr = r_j;
                n_hold    = ram_rdata;
            end
            S_REV_WR_LO: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
            end
            S_REV_WR_HI: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_hold;
                n_i       = r_i + IDX_W'(1);
                n_j       = r_j - IDX_W'(1);
            end
            S_EMIT_RD: begin
                ram_raddr = r_i;
            end
            // hand one element to the output register
            S_EMIT_OUT: begin
                ram_raddr = r_i;
                if (i_out_free) begin
                    o_emit.vld          = 1'b1;
                    o_emit.element      = ram_rdata;
                    o_emit.out_position = POS_W'(r_i);
                    o_emit.advanced     = r_adv;
                    o_emit.last_element = (r_i == r_last);
                    if (r_i != r_last) begin
                        n_i = r_i + IDX_W'(1);
                    end
                end
            end
            S_EMIT_ZERO: begin
                if (i_out_free) begin
                    o_emit.vld          = 1'b1;
                    o_emit.last_element = 1'b1;
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_last <= n_last;
        r_hold <= n_hold;
        r_adv  <= n_adv;
    end

    `NLP_ASSERT_IMP(a_emit_idx, i_clk, i_rst_n, (r_state == S_EMIT_OUT), (r_i <= r_last), "emit index past sequence end")
    `NLP_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_emit.vld, i_out_free, "result emitted into a full output register")
    `NLP_ASSERT_IMP(a_rev_order, i_clk, i_rst_n, (r_state == S_REV_WR_HI), (r_i < r_j), "reversal pair out of order")
    `NLP_ASSERT_IMP(a_swap_pos, i_clk, i_rst_n, (r_state == S_SWAP_WR), (r_k < r_j), "swap partner not right of pivot")
    `NLP_ASSERT_NXT(a_step_busy, i_clk, i_rst_n, ((r_state == S_IDLE) && step_req), (r_state != S_IDLE), "step request did not start")

endmodule
